[src/scheduled_dispenser_controller_top_defines.svh]
`ifndef SCHEDULED_DISPENSER_CONTROLLER_TOP_DEFINES_SVH
`define SCHEDULED_DISPENSER_CONTROLLER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define SDC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("dispenser check failed");
`define SDC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("dispenser check failed");
`else
`define SDC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SDC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

[src/sdc_pkg.sv]
package sdc_pkg;

	localparam int SLOT_COUNT = 16;

	localparam int DATA_IN_W = 128;
	localparam int USER_IN_W = 2;
	localparam int DATA_OUT_W = 8;
	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [1:0] CMD_STEP = 2'd0;
	localparam logic [1:0] CMD_RECHECK = 2'd1;
	localparam logic [1:0] CMD_WRITE = 2'd2;

	localparam logic [1:0] MODE_WAITING = 2'd0;
	localparam logic [1:0] MODE_FEEDING = 2'd1;
	localparam logic [1:0] MODE_FINDING = 2'd2;

	localparam logic [1:0] REG_ENTRY_COUNT = 2'd0;
	localparam logic [1:0] REG_TIMEOUT = 2'd1;
	localparam logic [1:0] REG_MIN_MASS = 2'd2;
	localparam logic [1:0] REG_PITCH_LIMIT = 2'd3;

	localparam logic [4:0] ENTRY_COUNT_RST = 5'd0;
	localparam logic [31:0] TIMEOUT_RST = 32'd60000;
	localparam logic [15:0] MIN_MASS_RST = 16'd5;
	localparam logic signed [15:0] PITCH_LIMIT_RST = 16'sd3000;

	localparam logic [10:0] MIN_PER_HOUR = 11'd60;

	typedef struct packed {
		logic [15:0] mass;
		logic [6:0] day;
		logic [5:0] minute;
		logic [4:0] hour;
	} entry_t;

	typedef struct packed {
		logic capture;
		logic wr_entry;
		logic rd_sel;
		logic scan_clr;
		logic scan_issue;
		logic recheck;
		logic start;
		logic feed_update;
		logic select;
		logic out_load;
	} ctl_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic [1:0] mode;
		logic wait_due;
		logic hit;
		logic scan_more;
		logic out_free;
	} sts_t;

endpackage

[src/sdc_ram.sv]
module sdc_ram #(
	parameter int WIDTH = 34,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[src/sdc_ctrl.sv]
`include "scheduled_dispenser_controller_top_defines.svh"

module sdc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  sdc_pkg::sts_t st,
	output sdc_pkg::ctl_t ctl
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DISP = 3'd1;
	localparam logic [2:0] ST_EVAL = 3'd2;
	localparam logic [2:0] ST_SCAN = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		ctl = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					ctl.capture = 1'b1;
					state_d = ST_DISP;
				end
			end
			ST_DISP: begin
				unique case (st.cmd)
					sdc_pkg::CMD_WRITE: begin
						ctl.wr_entry = 1'b1;
						state_d = ST_DONE;
					end
					sdc_pkg::CMD_RECHECK: begin
						ctl.recheck = 1'b1;
						state_d = ST_DONE;
					end
					sdc_pkg::CMD_STEP: begin
						if (st.mode == sdc_pkg::MODE_WAITING ||
							st.mode == sdc_pkg::MODE_FEEDING) begin
							ctl.rd_sel = 1'b1;
							state_d = ST_EVAL;
						end else begin
							ctl.scan_clr = 1'b1;
							state_d = ST_SCAN;
						end
					end
					default: begin
						state_d = ST_DONE;
					end
				endcase
			end
			ST_EVAL: begin
				if (st.mode == sdc_pkg::MODE_WAITING) begin
					ctl.start = st.wait_due;
				end else begin
					ctl.feed_update = 1'b1;
				end
				state_d = ST_DONE;
			end
			ST_SCAN: begin
				if (st.hit) begin
					ctl.select = 1'b1;
					state_d = ST_DONE;
				end else if (st.scan_more) begin
					ctl.scan_issue = 1'b1;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (st.out_free) begin
					ctl.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`SDC_ASSERT_NXT(a_capture_dispatch, clk, arst_n, ctl.capture, state_q == ST_DISP)
	`SDC_ASSERT_NXT(a_scan_end, clk, arst_n, (state_q == ST_SCAN) && !st.hit && !st.scan_more, state_q == ST_DONE)

endmodule

[src/sdc_datapath.sv]
`include "scheduled_dispenser_controller_top_defines.svh"

module sdc_datapath #(
	parameter int DEPTH = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  sdc_pkg::ctl_t                    ctl,
	output sdc_pkg::sts_t                    st,
	input  logic [sdc_pkg::DATA_IN_W-1:0]    s_tdata,
	input  logic [sdc_pkg::USER_IN_W-1:0]    s_tuser,
	input  logic                             cfg_we,
	input  logic [sdc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
	input  logic [sdc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [sdc_pkg::DATA_OUT_W-1:0]   m_tdata
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	function automatic logic [10:0] minute_of_day(input logic [4:0] hour,
		input logic [5:0] minute);
		return 11'(hour) * sdc_pkg::MIN_PER_HOUR + 11'(minute);
	endfunction

	// configuration
	logic [4:0] entry_count_q;
	logic [31:0] timeout_q;
	logic [15:0] min_mass_q;
	logic signed [15:0] pitch_limit_q;

	// captured item
	logic [1:0] cmd_q;
	logic [4:0] now_hour_q;
	logic [5:0] now_minute_q;
	logic [6:0] now_day_q;
	logic signed [23:0] mass_q;
	logic signed [15:0] pitch_q;
	logic [31:0] now_ms_q;
	logic [3:0] entry_index_q;
	sdc_pkg::entry_t entry_q;

	// controller state
	logic [1:0] mode_q;
	logic [3:0] slot_q;
	logic signed [23:0] start_mass_q;
	logic [31:0] start_time_q;
	logic servo_q;
	logic motor_q;

	logic [CW-1:0] scan_q;
	logic chk_q;
	logic [AW-1:0] chk_idx_q;

	logic out_valid_q;
	logic [sdc_pkg::DATA_OUT_W-1:0] out_data_q;

	logic ram_we;
	logic [AW-1:0] ram_raddr;
	logic [33:0] ram_rdata;
	sdc_pkg::entry_t rent;
	logic [10:0] cur_min;
	logic [10:0] ent_min;
	logic signed [25:0] gone;
	logic gone_ok;
	logic mass_above;
	logic [31:0] elapsed;
	logic time_ok;
	logic feed_ok;
	logic pitch_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= sdc_pkg::ENTRY_COUNT_RST;
			timeout_q <= sdc_pkg::TIMEOUT_RST;
			min_mass_q <= sdc_pkg::MIN_MASS_RST;
			pitch_limit_q <= sdc_pkg::PITCH_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				sdc_pkg::REG_ENTRY_COUNT: entry_count_q <= cfg_wdata[4:0];
				sdc_pkg::REG_TIMEOUT: timeout_q <= cfg_wdata[31:0];
				sdc_pkg::REG_MIN_MASS: min_mass_q <= cfg_wdata[15:0];
				sdc_pkg::REG_PITCH_LIMIT: pitch_limit_q <= $signed(cfg_wdata[15:0]);
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			cmd_q <= s_tuser;
			now_hour_q <= s_tdata[4:0];
			now_minute_q <= s_tdata[10:5];
			now_day_q <= s_tdata[17:11];
			mass_q <= $signed(s_tdata[41:18]);
			pitch_q <= $signed(s_tdata[57:42]);
			now_ms_q <= s_tdata[89:58];
			entry_index_q <= s_tdata[93:90];
			entry_q.hour <= s_tdata[98:94];
			entry_q.minute <= s_tdata[104:99];
			entry_q.day <= s_tdata[111:105];
			entry_q.mass <= s_tdata[127:112];
		end
	end

	assign ram_we = ctl.wr_entry && (5'(entry_index_q) < 5'(DEPTH));
	assign ram_raddr = ctl.rd_sel ? slot_q[AW-1:0] : scan_q[AW-1:0];

	sdc_ram #(
		.WIDTH(34),
		.DEPTH(DEPTH)
	) u_table (
		.clk(clk),
		.we(ram_we),
		.waddr(entry_index_q[AW-1:0]),
		.wdata(entry_q),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign rent = sdc_pkg::entry_t'(ram_rdata);
	assign cur_min = minute_of_day(now_hour_q, now_minute_q);
	assign ent_min = minute_of_day(rent.hour, rent.minute);

	assign gone = 26'(start_mass_q) - 26'(mass_q);
	assign gone_ok = gone < $signed({10'd0, rent.mass});
	assign mass_above = 25'(mass_q) > $signed({9'd0, min_mass_q});
	assign elapsed = now_ms_q - start_time_q;
	assign time_ok = elapsed < timeout_q;
	assign feed_ok = gone_ok && mass_above && time_ok;
	assign pitch_ok = pitch_q < pitch_limit_q;

	assign st.cmd = cmd_q;
	assign st.mode = mode_q;
	assign st.wait_due = cur_min >= ent_min;
	assign st.hit = chk_q && (cur_min < ent_min) && ((now_day_q & rent.day) != 7'd0);
	assign st.scan_more = (5'(scan_q) < entry_count_q) && (scan_q < CW'(DEPTH));
	assign st.out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0;
			chk_q <= 1'b0;
			chk_idx_q <= '0;
		end else if (ctl.scan_clr) begin
			scan_q <= '0;
			chk_q <= 1'b0;
		end else if (ctl.scan_issue) begin
			scan_q <= scan_q + 1'b1;
			chk_q <= 1'b1;
			chk_idx_q <= scan_q[AW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= sdc_pkg::MODE_FINDING;
			slot_q <= '0;
			start_mass_q <= '0;
			start_time_q <= '0;
			servo_q <= 1'b0;
			motor_q <= 1'b0;
		end else begin
			priority if (ctl.recheck) begin
				servo_q <= 1'b0;
				motor_q <= 1'b0;
				mode_q <= sdc_pkg::MODE_FINDING;
			end else if (ctl.start) begin
				start_mass_q <= mass_q;
				start_time_q <= now_ms_q;
				mode_q <= sdc_pkg::MODE_FEEDING;
			end else if (ctl.feed_update) begin
				if (feed_ok) begin
					servo_q <= 1'b1;
					motor_q <= pitch_ok;
				end else begin
					servo_q <= 1'b0;
					motor_q <= 1'b0;
					mode_q <= sdc_pkg::MODE_FINDING;
				end
			end else if (ctl.select) begin
				slot_q <= 4'(chk_idx_q);
				mode_q <= sdc_pkg::MODE_WAITING;
			end else begin
				mode_q <= mode_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			out_data_q <= {slot_q, mode_q, motor_q, servo_q};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = out_data_q;

	`SDC_ASSERT_NXT(a_select_waits, clk, arst_n, ctl.select, mode_q == sdc_pkg::MODE_WAITING)
	`SDC_ASSERT_IMP(a_servo_feeding, clk, arst_n, servo_q, mode_q == sdc_pkg::MODE_FEEDING)
	`SDC_ASSERT_IMP(a_motor_servo, clk, arst_n, motor_q, servo_q)

endmodule

[src/scheduled_dispenser_controller_top.sv]
// flow: capture, dispatch, then done, which loads the result once the output is free; a waiting
// or feeding step adds one table read, a search reads entries until a hit or the entry count
// throughput: one item at a time, next transfer taken the cycle after the result is loaded
// the search reads one schedule entry per cycle from the single table read port
// reset: asynchronous, mode finding, slot 0, drives off, config at defaults
// schedule table contents undefined until written, no clearing pass
module scheduled_dispenser_controller_top #(
	parameter int MAX_ENTRIES = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// now_hour, now_minute, now_day, mass_sample, pitch, now_ms, entry_index,
	// entry_hour, entry_minute, entry_day, entry_mass
	input  logic [sdc_pkg::DATA_IN_W-1:0]    s_tdata,
	// cmd
	input  logic [sdc_pkg::USER_IN_W-1:0]    s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// gate_drive, feed_drive, mode, next_slot
	output logic [sdc_pkg::DATA_OUT_W-1:0]   m_tdata,
	input  logic                             cfg_we,
	input  logic [sdc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
	input  logic [sdc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

	localparam int TAB_DEPTH = (MAX_ENTRIES < sdc_pkg::SLOT_COUNT) ?
		MAX_ENTRIES : sdc_pkg::SLOT_COUNT;

	sdc_pkg::ctl_t ctl;
	sdc_pkg::sts_t st;

	sdc_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.st(st),
		.ctl(ctl)
	);

	sdc_datapath #(
		.DEPTH(TAB_DEPTH)
	) u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(ctl),
		.st(st),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

endmodule
